### sv/xmcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xmcb_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_ALIVE   = 3'd1,
        OP_SET_TCP = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_OLDEST  = 3'd5,
        OP_CLOSEST = 3'd6,
        OP_UNUSED  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // one stored contact
    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [31:0] address;
        logic [15:0] udp_port;
        logic [15:0] tcp_port;
        logic [2:0]  ctype;
    } t_contact;

endpackage
`default_nettype wire

### sv/xmcb_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module xmcb_mem
    import xmcb_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire t_contact       i_wdata,
    input  wire logic [AW-1:0]  i_raddr,
    output t_contact            o_rdata
);

    t_contact r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/xor_metric_contact_bucket_core.sv
`timescale 1ns / 1ps
`default_nettype none
// contact bucket, least-recently-seen order, contacts in one single-port-read memory
// all ops but closest scan the n entries, one read per cycle, then decide in S_DEC
// alive, set_tcp and remove, on a hit, then shift later entries down (S_SHRD, S_SHWR) and finish in S_TAIL
// closest: one scan of n entries per result beat
// one item at a time; throughput set by the single memory read port
// reset (synchronous, i_rst_n low) empties the bucket; memory contents untouched
module xor_metric_contact_bucket_core
    import xmcb_pkg::*;
#(
    parameter int BUCKET_SIZE = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_node_id_high,
    input  wire logic [63:0] i_node_id_low,
    input  wire logic [31:0] i_ip_address,
    input  wire logic [15:0] i_udp_port_in,
    input  wire logic [15:0] i_tcp_port_in,
    input  wire logic [2:0]  i_type_in,
    input  wire logic [2:0]  i_max_type,
    input  wire logic [3:0]  i_max_required,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_out_id_high,
    output logic [63:0]      o_out_id_low,
    output logic [31:0]      o_out_address,
    output logic [15:0]      o_out_udp_port,
    output logic [15:0]      o_out_tcp_port,
    output logic [2:0]       o_out_type,
    output logic [5:0]       o_entry_count,
    output logic             o_last
);

    localparam int AW = $clog2(BUCKET_SIZE);
    localparam int CW = $clog2(BUCKET_SIZE + 1);

    // one-hot controller states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010, // issue reads, compare returned entries
        S_DEC   = 8'b0000_0100, // decide after the scan
        S_SHRD  = 8'b0000_1000, // shift: read entry j+1
        S_SHWR  = 8'b0001_0000, // shift: write entry j
        S_TAIL  = 8'b0010_0000, // write moved contact at the tail
        S_EMIT  = 8'b0100_0000, // result register loaded, wait for take
        S_CSCAN = 8'b1000_0000  // closest: pick next nearest above bound
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_op               r_op;
    t_contact          r_key;
    logic [2:0]        r_maxt;
    logic [3:0]        r_maxr;
    logic [4:0]        r_sent;

    // scan bookkeeping: issue address and returned-entry index
    logic [CW-1:0]     r_ra, n_ra;
    logic              r_rv, n_rv;      // read data valid this cycle
    logic [AW-1:0]     r_ridx, n_ridx;
    logic              r_hit, n_hit;
    logic [AW-1:0]     r_hidx, n_hidx;
    t_contact          r_hold, n_hold;  // matched / best contact
    logic [CW-1:0]     r_sj, n_sj;      // shift position
    // closest: previous bound
    logic              r_hasb, n_hasb;
    logic [127:0]      r_bound, n_bound;
    logic [127:0]      r_bestd, n_bestd;

    // output register
    logic              r_ov, n_ov;
    t_status           r_st, n_st;
    t_contact          r_oc, n_oc;
    logic [5:0]        r_oe, n_oe;
    logic              r_ol, n_ol;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    t_contact          w_wdata, w_rdata;

    xmcb_mem #(.DEPTH(BUCKET_SIZE), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wire logic w_take = i_valid && !o_stall;
    wire logic w_out_take = r_ov && !i_stall;

    logic          w_match;
    logic [127:0]  w_dist;
    logic          w_elig;

    assign o_stall = (r_state != S_IDLE) || r_ov;

    always_comb begin
        w_dist = {w_rdata.id_high ^ r_key.id_high, w_rdata.id_low ^ r_key.id_low};
        if (r_op == OP_ALIVE || r_op == OP_SET_TCP) begin
            w_match = (w_rdata.address == r_key.address)
                   && (w_rdata.udp_port == r_key.udp_port);
        end else if (r_op == OP_OLDEST) begin
            // head entry
            w_match = (r_ridx == '0);
        end else begin
            w_match = (w_rdata.id_high == r_key.id_high)
                   && (w_rdata.id_low == r_key.id_low);
        end
        w_elig = (w_rdata.ctype <= r_maxt) && (!r_hasb || (w_dist > r_bound))
              && (!r_hit || (w_dist < r_bestd));
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ra    = r_ra;
        n_rv    = 1'b0;
        n_ridx  = r_ridx;
        n_hit   = r_hit;
        n_hidx  = r_hidx;
        n_hold  = r_hold;
        n_sj    = r_sj;
        n_hasb  = r_hasb;
        n_bound = r_bound;
        n_bestd = r_bestd;
        n_ov    = r_ov;
        n_st    = r_st;
        n_oc    = r_oc;
        n_oe    = r_oe;
        n_ol    = r_ol;
        w_we    = 1'b0;
        w_waddr = r_sj[AW-1:0];
        w_wdata = r_hold;
        w_raddr = r_ra[AW-1:0];

        if (w_out_take) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_ra   = '0;
                    n_hit  = 1'b0;
                    n_hasb = 1'b0;
                    n_state = (t_op'(i_opcode) == OP_CLOSEST) ? S_CSCAN : S_SCAN;
                end
            end
            S_SCAN, S_CSCAN: begin
                // issue one read per cycle while entries remain
                if (r_ra < r_count) begin
                    n_rv   = 1'b1;
                    n_ridx = r_ra[AW-1:0];
                    n_ra   = r_ra + CW'(1);
                end
                if (r_rv) begin
                    if (r_state == S_SCAN) begin
                        if (w_match && !r_hit) begin
                            n_hit  = 1'b1;
                            n_hidx = r_ridx;
                            n_hold = w_rdata;
                        end
                    end else if (w_elig) begin
                        n_hit   = 1'b1;
                        n_hold  = w_rdata;
                        n_bestd = w_dist;
                    end
                end
                if (r_ra >= r_count && !r_rv) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_ol = 1'b1;
                    n_oc = '0;
                    n_st = ST_NOTFOUND;
                    n_oe = 6'(r_count);
                    n_state = S_EMIT;
                    priority case (r_op)
                        OP_ADD: begin
                            if (r_hit) begin
                                n_st = ST_DUP;
                                n_oc = r_hold;
                            end else if (r_count >= CW'(BUCKET_SIZE)) begin
                                n_st = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = r_key;
                                n_st    = ST_OK;
                                n_oc    = r_key;
                                n_count = r_count + CW'(1);
                                n_oe    = 6'(r_count + CW'(1));
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_hit) begin
                                n_st = ST_OK;
                                n_oc = r_hold;
                            end
                        end
                        OP_OLDEST: begin
                            if (r_count != '0) begin
                                n_st = ST_OK;
                                n_oc = r_hold;
                            end
                        end
                        OP_ALIVE, OP_SET_TCP, OP_REMOVE: begin
                            if (r_hit) begin
                                // hold output until shift finishes
                                n_ov = 1'b0;
                                if (r_op == OP_SET_TCP) begin
                                    n_hold.tcp_port = r_key.tcp_port;
                                end
                                n_sj = CW'(r_hidx);
                                n_state = S_SHRD;
                            end
                        end
                        OP_CLOSEST: begin
                            if (r_hit && (5'(r_sent) < 5'(r_maxr))) begin
                                n_st    = ST_OK;
                                n_oc    = r_hold;
                                n_ol    = 1'b0;
                                n_bound = r_bestd;
                                n_hasb  = 1'b1;
                            end else if (r_sent != '0) begin
                                // already done; previous beat was final
                                n_ov = 1'b0;
                                n_state = S_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHRD: begin
                if (r_sj + CW'(1) < r_count) begin
                    w_raddr = AW'(r_sj + CW'(1));
                    n_state = S_SHWR;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_sj[AW-1:0];
                w_wdata = w_rdata;
                n_sj    = r_sj + CW'(1);
                n_state = S_SHRD;
            end
            S_TAIL: begin
                n_ov = 1'b1;
                n_ol = 1'b1;
                n_st = ST_OK;
                n_oc = r_hold;
                if (r_op == OP_REMOVE) begin
                    n_count = r_count - CW'(1);
                    n_oe    = 6'(r_count - CW'(1));
                end else begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_count - CW'(1));
                    w_wdata = r_hold;
                    n_oe    = 6'(r_count);
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_take) begin
                    if (r_op == OP_CLOSEST && !r_ol) begin
                        n_ra  = '0;
                        n_hit = 1'b0;
                        n_state = S_CSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // closest: contacts of admitted type, counted on the first scan
    logic [CW-1:0] r_nelig;

    // closest: a beat is final when max_required is reached or no candidate is left
    logic w_cl_final;
    assign w_cl_final = (r_sent + 5'd1 >= 5'(r_maxr))
                     || (6'(r_sent) + 6'd1 >= 6'(r_nelig));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_rv    <= n_rv;
            if (r_state == S_IDLE && w_take) begin
                r_sent <= '0;
            end else if (r_state == S_DEC && n_ov && r_op == OP_CLOSEST && !n_ol) begin
                r_sent <= r_sent + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra    <= n_ra;
        r_ridx  <= n_ridx;
        r_hit   <= n_hit;
        r_hidx  <= n_hidx;
        r_hold  <= n_hold;
        r_sj    <= n_sj;
        r_hasb  <= n_hasb;
        r_bound <= n_bound;
        r_bestd <= n_bestd;
        r_st    <= n_st;
        r_oc    <= n_oc;
        r_oe    <= n_oe;
        r_ol    <= (r_state == S_DEC && r_op == OP_CLOSEST && n_ov && !n_ol)
                   ? w_cl_final : n_ol;
        if (r_state == S_IDLE && w_take) begin
            r_nelig <= '0;
        end else if (r_state == S_CSCAN && r_rv && !r_hasb && (w_rdata.ctype <= r_maxt)) begin
            r_nelig <= r_nelig + CW'(1);
        end
        if (r_state == S_IDLE && w_take) begin
            r_op   <= t_op'(i_opcode);
            r_key  <= '{id_high: i_node_id_high, id_low: i_node_id_low,
                        address: i_ip_address, udp_port: i_udp_port_in,
                        tcp_port: i_tcp_port_in, ctype: i_type_in};
            r_maxt <= i_max_type;
            r_maxr <= i_max_required;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_st;
    assign o_out_id_high  = r_oc.id_high;
    assign o_out_id_low   = r_oc.id_low;
    assign o_out_address  = r_oc.address;
    assign o_out_udp_port = r_oc.udp_port;
    assign o_out_tcp_port = r_oc.tcp_port;
    assign o_out_type     = r_oc.ctype;
    assign o_entry_count  = r_oe;
    assign o_last         = r_ol;

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(BUCKET_SIZE);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("occupancy overflow");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_oe <= 6'(BUCKET_SIZE))) else $error("bad entry count");

endmodule
`default_nettype wire

### tb/xor_metric_contact_bucket_core_test.sv
`timescale 1ns / 1ps
`default_nettype none
module xor_metric_contact_bucket_core_test;
    import xmcb_pkg::*;

    localparam int BUCKET_SIZE = 10;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;

    // one expected result beat
    typedef struct packed {
        logic [1:0]  status;
        t_contact    contact;
        logic [5:0]  count;
        logic        last;
    } t_beat;

    // one directed row; has_exp marks rows whose first beat is typed in
    typedef struct {
        t_op         op;
        logic [63:0] idh;
        logic [63:0] idl;
        logic [31:0] ip;
        logic [15:0] udp;
        logic [15:0] tcp;
        logic [2:0]  ty;
        logic [2:0]  maxt;
        logic [3:0]  maxr;
        bit          has_exp;
        t_status     exp_status;
        logic [5:0]  exp_count;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [63:0] idh_in;
    logic [63:0] idl_in;
    logic [31:0] ip_in;
    logic [15:0] udp_in;
    logic [15:0] tcp_in;
    logic [2:0]  ty_in;
    logic [2:0]  maxt_in;
    logic [3:0]  maxr_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  st_out;
    logic [63:0] idh_out;
    logic [63:0] idl_out;
    logic [31:0] ip_out;
    logic [15:0] udp_out;
    logic [15:0] tcp_out;
    logic [2:0]  ty_out;
    logic [5:0]  cnt_out;
    logic        last_out;

    // predictor copy of the bucket, oldest contact in slot 0
    t_contact bucket [BUCKET_SIZE];
    int       held;
    t_beat    pending_beats [$];
    t_row     rows [$];
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_recv;

    // endpoint and id pools keep random ops colliding with held contacts
    logic [63:0] pool_h [16];
    logic [63:0] pool_l [16];
    logic [31:0] pool_ip [16];
    logic [15:0] pool_udp [16];

    xor_metric_contact_bucket_core #(.BUCKET_SIZE(BUCKET_SIZE)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode), .i_node_id_high(idh_in), .i_node_id_low(idl_in),
        .i_ip_address(ip_in), .i_udp_port_in(udp_in), .i_tcp_port_in(tcp_in),
        .i_type_in(ty_in), .i_max_type(maxt_in), .i_max_required(maxr_in),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(st_out),
        .o_out_id_high(idh_out), .o_out_id_low(idl_out),
        .o_out_address(ip_out), .o_out_udp_port(udp_out),
        .o_out_tcp_port(tcp_out), .o_out_type(ty_out),
        .o_entry_count(cnt_out), .o_last(last_out)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void queue_beat(t_beat b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic t_beat make_beat(t_status st, int slot, bit is_last);
        t_beat b;
        b.status = st;
        b.contact = (slot >= 0) ? bucket[slot] : '0;
        b.count = held[5:0];
        b.last = is_last;
        return b;
    endfunction

    function automatic int slot_of_id(logic [63:0] h, logic [63:0] l);
        for (int i = 0; i < held; i++)
            if (bucket[i].id_high == h && bucket[i].id_low == l)
                return i;
        return -1;
    endfunction

    function automatic int slot_of_endpoint(logic [31:0] a, logic [15:0] u);
        for (int i = 0; i < held; i++)
            if (bucket[i].address == a && bucket[i].udp_port == u)
                return i;
        return -1;
    endfunction

    function automatic void drop_slot(int s);
        for (int j = s; j + 1 < held; j++)
            bucket[j] = bucket[j + 1];
        held--;
    endfunction

    // applies one operation to the bucket copy and queues its result beats
    function automatic void predict_bucket(t_op op, logic [63:0] h, logic [63:0] l,
                                           logic [31:0] a, logic [15:0] u,
                                           logic [15:0] t, logic [2:0] ty,
                                           logic [2:0] maxt, logic [3:0] maxr);
        int s;
        int order [BUCKET_SIZE];
        int n;
        int j;
        t_contact c;
        case (op)
            OP_ADD: begin
                s = slot_of_id(h, l);
                if (s >= 0) begin
                    queue_beat(make_beat(ST_DUP, s, 1));
                end else if (held >= BUCKET_SIZE) begin
                    queue_beat(make_beat(ST_FULL, -1, 1));
                end else begin
                    bucket[held] = '{h, l, a, u, t, ty};
                    held++;
                    queue_beat(make_beat(ST_OK, held - 1, 1));
                end
            end
            OP_ALIVE, OP_SET_TCP: begin
                s = slot_of_endpoint(a, u);
                if (s < 0) begin
                    queue_beat(make_beat(ST_NOTFOUND, -1, 1));
                end else begin
                    if (op == OP_SET_TCP)
                        bucket[s].tcp_port = t;
                    c = bucket[s];
                    drop_slot(s);
                    bucket[held] = c;
                    held++;
                    queue_beat(make_beat(ST_OK, held - 1, 1));
                end
            end
            OP_REMOVE: begin
                s = slot_of_id(h, l);
                if (s < 0) begin
                    queue_beat(make_beat(ST_NOTFOUND, -1, 1));
                end else begin
                    c = bucket[s];
                    drop_slot(s);
                    queue_beat('{ST_OK, c, held[5:0], 1'b1});
                end
            end
            OP_LOOKUP: begin
                s = slot_of_id(h, l);
                queue_beat(make_beat(s >= 0 ? ST_OK : ST_NOTFOUND, s, 1));
            end
            OP_OLDEST: begin
                queue_beat(make_beat(held > 0 ? ST_OK : ST_NOTFOUND,
                                     held > 0 ? 0 : -1, 1));
            end
            OP_CLOSEST: begin
                // insertion sort by xor distance over admitted types
                n = 0;
                for (int i = 0; i < held; i++) begin
                    if (bucket[i].ctype <= maxt) begin
                        j = n;
                        while (j > 0 && ({bucket[i].id_high, bucket[i].id_low} ^ {h, l}) <
                               ({bucket[order[j-1]].id_high, bucket[order[j-1]].id_low}
                                ^ {h, l})) begin
                            order[j] = order[j - 1];
                            j--;
                        end
                        order[j] = i;
                        n++;
                    end
                end
                if (n > maxr)
                    n = maxr;
                if (n == 0)
                    queue_beat(make_beat(ST_NOTFOUND, -1, 1));
                for (int k = 0; k < n; k++)
                    queue_beat(make_beat(ST_OK, order[k], k == n - 1));
            end
            default: begin
                queue_beat(make_beat(ST_NOTFOUND, -1, 1));
            end
        endcase
    endfunction

    // drive one beat at the falling edge and hold it until accepted
    task automatic send_beat(t_op op, logic [63:0] h, logic [63:0] l, logic [31:0] a,
                             logic [15:0] u, logic [15:0] t, logic [2:0] ty,
                             logic [2:0] maxt, logic [3:0] maxr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        idh_in <= h;
        idl_in <= l;
        ip_in <= a;
        udp_in <= u;
        tcp_in <= t;
        ty_in <= ty;
        maxt_in <= maxt;
        maxr_in <= maxr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_bucket(op, h, l, a, u, t, ty, maxt, maxr);
        // valid is dropped or reloaded by whoever drives next
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
    endtask

    // random item, mostly aimed at pooled ids and endpoints
    task automatic send_random();
        int p;
        t_op op;
        logic [63:0] h;
        logic [63:0] l;
        logic [31:0] a;
        logic [15:0] u;
        p = $urandom_range(15);
        op = t_op'($urandom_range(99) < 25 ? OP_ADD : $urandom_range(7));
        h = pool_h[p];
        l = pool_l[p];
        a = pool_ip[p];
        u = pool_udp[p];
        if ($urandom_range(9) == 0) begin
            h = {$urandom, $urandom};
            l = {$urandom, $urandom};
            a = $urandom;
            u = 16'($urandom);
        end
        // never hand out two pooled endpoints with the same id via noise
        send_beat(op, h, l, a, u, 16'($urandom), 3'($urandom_range(7)),
                  3'($urandom_range(7)), 4'($urandom_range(15)));
    endtask

    initial begin
        t_beat b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = OP_ADD;
        idh_in = '0;
        idl_in = '0;
        ip_in = '0;
        udp_in = '0;
        tcp_in = '0;
        ty_in = '0;
        maxt_in = '0;
        maxr_in = '0;
        errors = 0;
        held = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 1'b0;
        for (int i = 0; i < 16; i++) begin
            pool_h[i] = {$urandom, $urandom};
            pool_l[i] = {$urandom, 28'($urandom), 4'(i)};
            pool_ip[i] = $urandom;
            pool_udp[i] = 16'(i * 4099 + 1);
        end
        pool_h[0] = '0;
        pool_l[0] = '0;
        pool_ip[0] = '0;
        pool_udp[0] = '0;
        pool_h[1] = '1;
        pool_l[1] = '1;
        pool_ip[1] = '1;
        pool_udp[1] = '1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty bucket, extremes, every op, full, dup, none, opcode 7
        add_row('{OP_OLDEST, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND, 0});
        add_row('{OP_CLOSEST, 0, 0, 0, 0, 0, 0, 7, 15, 1, ST_NOTFOUND, 0});
        add_row('{OP_LOOKUP, '1, '1, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND, 0});
        add_row('{OP_ALIVE, 0, 0, '1, '1, 0, 0, 0, 0, 1, ST_NOTFOUND, 0});
        add_row('{OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND, 0});
        add_row('{OP_UNUSED, '1, '1, '1, '1, '1, 7, 7, 15, 1, ST_NOTFOUND, 0});
        add_row('{OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0});
        add_row('{OP_ADD, '1, '1, '1, '1, '1, 7, 0, 0, 0, ST_OK, 0});
        for (int i = 2; i < 10; i++)
            add_row('{OP_ADD, pool_h[i], pool_l[i], pool_ip[i], pool_udp[i],
                      16'(i), 3'(i % 5), 0, 0, 0, ST_OK, 0});
        add_row('{OP_ADD, pool_h[11], pool_l[11], 0, 0, 0, 0, 0, 0,
                  1, ST_FULL, 10});
        add_row('{OP_ADD, '1, '1, 0, 0, 0, 0, 0, 0, 0, ST_DUP, 0});
        add_row('{OP_CLOSEST, 0, 0, 0, 0, 0, 0, 7, 15, 0, ST_OK, 0});
        add_row('{OP_CLOSEST, '1, '1, 0, 0, 0, 0, 2, 3, 0, ST_OK, 0});
        add_row('{OP_CLOSEST, 0, 0, 0, 0, 0, 0, 7, 0, 0, ST_OK, 0});
        add_row('{OP_ALIVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0});
        add_row('{OP_SET_TCP, 0, 0, pool_ip[3], pool_udp[3], '1, 0, 0, 0,
                  0, ST_OK, 0});
        add_row('{OP_OLDEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0});
        add_row('{OP_REMOVE, pool_h[5], pool_l[5], 0, 0, 0, 0, 0, 0, 0, ST_OK, 0});
        add_row('{OP_LOOKUP, pool_h[6], pool_l[6], 0, 0, 0, 0, 0, 0, 0, ST_OK, 0});

        foreach (rows[r]) begin
            send_beat(rows[r].op, rows[r].idh, rows[r].idl, rows[r].ip, rows[r].udp,
                      rows[r].tcp, rows[r].ty, rows[r].maxt, rows[r].maxr);
            if (rows[r].has_exp) begin
                // the typed-in answer must agree with the predictor's
                b = pending_beats[pending_beats.size() - 1];
                if (b.status != rows[r].exp_status || b.count != rows[r].exp_count) begin
                    $display("%0t directed row %0d: expected status %0d count %0d, got %0d %0d",
                             $time, r, rows[r].exp_status, rows[r].exp_count,
                             b.status, b.count);
                    errors++;
                end
            end
        end
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 29) : 0;
            recv_idle_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 29) : 0;
            for (int n = 0; n < 60; n++)
                send_random();
            // sender waits for all results before the next phase
            wait_drained();
        end

        // long receiver hold while the sender keeps offering beats
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 1'b1;
        for (int n = 0; n < 20; n++)
            send_random();
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver stall pattern, including one long hold counted here
    initial begin
        int hold_cycles;
        hold_cycles = 0;
        forever begin
            @(negedge clk);
            if (hold_recv && hold_cycles < 400) begin
                hold_cycles++;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge clk) begin
        t_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat: status %0d id %h%h", $time, st_out,
                         idh_out, idl_out);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                if (st_out !== want.status || idh_out !== want.contact.id_high ||
                    idl_out !== want.contact.id_low || ip_out !== want.contact.address ||
                    udp_out !== want.contact.udp_port ||
                    tcp_out !== want.contact.tcp_port ||
                    ty_out !== want.contact.ctype || cnt_out !== want.count ||
                    last_out !== want.last) begin
                    $display("%0t mismatch: expected %0d %h %h %h %h %h %0d %0d %0d",
                             $time, want.status, want.contact.id_high,
                             want.contact.id_low, want.contact.address,
                             want.contact.udp_port, want.contact.tcp_port,
                             want.contact.ctype, want.count, want.last);
                    $display("%0t   actual:        %0d %h %h %h %h %h %0d %0d %0d",
                             $time, st_out, idh_out, idl_out, ip_out, udp_out,
                             tcp_out, ty_out, cnt_out, last_out);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

### sim.f
sv/xmcb_pkg.sv
sv/xmcb_mem.sv
sv/xor_metric_contact_bucket_core.sv
tb/xor_metric_contact_bucket_core_test.sv
